FILE: src/itoa_pkg.sv
// Shared types, constants and the power-of-ten table for the integer-to-ASCII block.
// Used by itoa_ctrl, itoa_dp and int32_to_decimal_ascii; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int unsigned MAG_W     = 32;
    localparam int unsigned THR_W     = 34;   // holds 9 * 10^9
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned POW_IDX_W = 4;

    localparam logic [POW_IDX_W-1:0] TOP_POW_IDX = 4'd9;
    localparam logic [POW_IDX_W-1:0] LOW_POW_IDX = 4'd0;
    localparam logic [CHAR_W-1:0]    ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]    ASCII_MINUS = 8'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic last_power;
        logic out_free;
    } t_status;

    // Ten to the power idx, for idx 0..9.
    function automatic logic [THR_W-1:0] pow10(input logic [POW_IDX_W-1:0] idx);
        logic [THR_W-1:0] p;
        case (idx)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: src/itoa_ctrl.sv
// Controller state machine of the integer-to-ASCII block.
// Depends on itoa_pkg; drives commands into itoa_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output itoa_pkg::t_cmd        o_cmd,
    input  wire itoa_pkg::t_status i_status
);

    itoa_pkg::t_state r_state;
    itoa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = itoa_pkg::ST_SIGN;
                end
            end
            itoa_pkg::ST_SIGN: begin
                if (!i_status.negative || i_status.out_free) begin
                    n_state = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_DIGIT: begin
                if (i_status.out_free && i_status.last_power) begin
                    n_state = itoa_pkg::ST_IDLE;
                end
            end
            default: n_state = itoa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.emit_sign = 1'b0;
        o_cmd.step      = 1'b0;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            itoa_pkg::ST_SIGN: begin
                o_cmd.emit_sign = i_status.negative && i_status.out_free;
            end
            itoa_pkg::ST_DIGIT: begin
                o_cmd.step = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // A digit step must never overwrite a word still waiting at the output.
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step || o_cmd.emit_sign) |-> i_status.out_free)
        else $error("datapath advanced while the output register was full");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.emit_sign, o_cmd.step}))
        else $error("more than one datapath command in a cycle");

    // After the units digit has been handed over, the block is ready again.
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_status.last_power) |=> o_in_ready)
        else $error("controller did not return to idle after the last digit");

endmodule

`default_nettype wire

FILE: src/itoa_dp.sv
// Datapath of the integer-to-ASCII block: magnitude, digit extraction and output register.
// Depends on itoa_pkg; commanded by itoa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic signed [itoa_pkg::MAG_W-1:0] i_value,
    input  wire itoa_pkg::t_cmd                    i_cmd,
    output itoa_pkg::t_status                      o_status,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]            o_character,
    output logic                                   o_last
);

    logic [itoa_pkg::MAG_W-1:0]     r_mag;
    logic [itoa_pkg::POW_IDX_W-1:0] r_pow_idx;
    logic                           r_started;
    logic                           r_neg;
    logic                           r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]    r_out_char;
    logic                           r_out_last;

    logic [itoa_pkg::MAG_W-1:0] w_raw;
    logic [itoa_pkg::THR_W-1:0] w_pow;
    logic [itoa_pkg::THR_W-1:0] w_sub;
    logic [3:0]                 w_digit;
    logic                       w_emit;
    logic                       w_is_units;
    logic                       w_out_free;

    assign w_raw      = unsigned'(i_value);
    assign w_is_units = (r_pow_idx == itoa_pkg::LOW_POW_IDX);
    assign w_out_free = !r_out_valid || i_out_ready;

    // The digit is the largest k in 1..9 with k * 10^idx not above the magnitude, or 0 if none.
    always_comb begin
        logic [itoa_pkg::THR_W-1:0] thr;
        w_pow   = itoa_pkg::pow10(r_pow_idx);
        w_digit = 4'd0;
        w_sub   = '0;
        for (int k = 1; k <= 9; k++) begin
            thr = w_pow * itoa_pkg::THR_W'(k);
            if ({2'b00, r_mag} >= thr) begin
                w_digit = 4'(k);
                w_sub   = thr;
            end
        end
    end

    assign w_emit = (w_digit != 4'd0) || r_started || w_is_units;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_pow_idx   <= itoa_pkg::TOP_POW_IDX;
        end else begin
            if (i_cmd.load) begin
                r_started <= 1'b0;
                r_pow_idx <= itoa_pkg::TOP_POW_IDX;
            end else if (i_cmd.step) begin
                r_started <= r_started || w_emit;
                if (!w_is_units) begin
                    r_pow_idx <= r_pow_idx - 4'd1;
                end
            end
            if (i_cmd.emit_sign || (i_cmd.step && w_emit)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= w_raw[itoa_pkg::MAG_W-1];
            r_mag <= w_raw[itoa_pkg::MAG_W-1] ? (~w_raw + 32'd1) : w_raw;
        end else if (i_cmd.step) begin
            r_mag <= r_mag - w_sub[itoa_pkg::MAG_W-1:0];
        end
        if (i_cmd.emit_sign) begin
            r_out_char <= itoa_pkg::ASCII_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.step && w_emit) begin
            r_out_char <= itoa_pkg::ASCII_ZERO + {4'd0, w_digit};
            r_out_last <= w_is_units;
        end
    end

    assign o_status.negative   = r_neg;
    assign o_status.last_power = w_is_units;
    assign o_status.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

FILE: src/int32_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on itoa_pkg and instantiates itoa_ctrl and itoa_dp.
`timescale 1ns / 1ps
`default_nettype none

// This block takes one signed 32-bit integer per input word and returns its
// decimal text as a stream of output words, one ASCII character each. A
// negative number starts with '-', the digits follow most significant first
// without leading zeros, zero gives the single character '0', and the most
// negative value comes out exactly as "-2147483648". The last character of a
// number is flagged with o_last; no terminating NUL is sent. The accepting
// cycle loads the magnitude, then come the sign slot and the ten digit
// steps, one per power of ten from 10^9 down to 10^0. Each step compares
// the magnitude against the nine multiples of that power in parallel.
// Input ready returns only after the last digit step, so no new number is
// taken while one is being converted. A stalled output stretches a
// conversion by the time spent waiting, since the sign slot of a negative
// number and every digit step, leading zeros included, wait for room in a
// single output register. The next number is accepted while the final
// character of the previous one is still waiting to be taken.

module int32_to_decimal_ascii (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [itoa_pkg::MAG_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]            o_character,
    output logic                                   o_last
);

    // Commands flow from the controller to the datapath, status back.
    itoa_pkg::t_cmd    w_cmd;
    itoa_pkg::t_status w_status;

    itoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // The datapath owns the magnitude, the digit position and the output
    // register that holds the word currently offered downstream.
    itoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
